>>> design/component_lifecycle_fsm_assert.svh
// ----------------------------------------------------------------------------
// component_lifecycle_fsm_assert.svh
// assertion macros used by the lifecycle supervisor checker
// ----------------------------------------------------------------------------
`ifndef COMPONENT_LIFECYCLE_FSM_ASSERT_SVH
`define COMPONENT_LIFECYCLE_FSM_ASSERT_SVH

// property must hold at every edge out of reset
`define CLFSM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold at the edge after the antecedent
`define CLFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/clfsm_pkg.sv
// ----------------------------------------------------------------------------
// clfsm_pkg
// types, codes and the transition table of the lifecycle supervisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clfsm_pkg;

  typedef enum logic [2:0] {
    M_START = 3'd0,
    M_INIT  = 3'd1,
    M_CONF  = 3'd2,
    M_READY = 3'd3,
    M_RUN   = 3'd4,
    M_RECOV = 3'd5,
    M_STOP  = 3'd6,
    M_NONE  = 3'd7
  } mode_t;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_STOP   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [3:0] OC_INITIALISED = 4'd0;
  localparam logic [3:0] OC_INIT_FAILED = 4'd1;
  localparam logic [3:0] OC_CONFIG_OK   = 4'd2;
  localparam logic [3:0] OC_CONFIGURE   = 4'd3;
  localparam logic [3:0] OC_RECONFIG_OK = 4'd4;
  localparam logic [3:0] OC_RETRY       = 4'd5;
  localparam logic [3:0] OC_CONFIG_FAIL = 4'd6;
  localparam logic [3:0] OC_WAIT        = 4'd7;
  localparam logic [3:0] OC_RUN         = 4'd8;
  localparam logic [3:0] OC_CONTINUE    = 4'd9;
  localparam logic [3:0] OC_DONE        = 4'd10;
  localparam logic [3:0] OC_RECOVER     = 4'd11;
  localparam logic [3:0] OC_RECOV_OK    = 4'd12;
  localparam logic [3:0] OC_RECOV_FAIL  = 4'd13;
  localparam logic [3:0] TAKEN_NONE     = 4'd14;

  localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd3;

  typedef struct packed {
    mode_t cur;
    mode_t prev;
    logic  cfgd;
    logic  alive;
  } sup_state_t;

  // listed transitions; M_NONE where the table has no entry
  function automatic mode_t next_mode(input mode_t mode, input logic [3:0] oc);
    mode_t res;
    res = M_NONE;
    unique case (mode)
      M_INIT: begin
        if (oc == OC_INITIALISED) res = M_CONF;
        else if (oc == OC_INIT_FAILED) res = M_RECOV;
      end
      M_CONF: begin
        if (oc == OC_CONFIG_OK) res = M_READY;
        else if (oc == OC_RETRY) res = M_CONF;
        else if (oc == OC_CONFIG_FAIL) res = M_STOP;
      end
      M_READY: begin
        if (oc == OC_CONFIGURE) res = M_CONF;
        else if (oc == OC_WAIT) res = M_READY;
        else if (oc == OC_RUN) res = M_RUN;
      end
      M_RUN: begin
        if (oc == OC_CONFIGURE) res = M_CONF;
        else if (oc == OC_CONTINUE) res = M_RUN;
        else if (oc == OC_DONE) res = M_READY;
        else if (oc == OC_RECOVER) res = M_RECOV;
      end
      M_RECOV: begin
        if (oc == OC_RECOV_FAIL) res = M_STOP;
      end
      default: res = M_NONE;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/clfsm_in_stage.sv
// ----------------------------------------------------------------------------
// clfsm_in_stage
// input register holding one request until the core takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clfsm_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [3:0] in_outcome,
  input  wire logic       take,
  output logic            s1_valid,
  output logic [1:0]      s1_operation,
  output logic [3:0]      s1_outcome
);

  logic       valid_r;
  logic       valid_nxt;
  logic [1:0] op_r;
  logic [3:0] oc_r;
  logic       load;

  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= in_operation;
      oc_r <= in_outcome;
    end
  end

  assign s1_valid     = valid_r;
  assign s1_operation = op_r;
  assign s1_outcome   = oc_r;

endmodule

`default_nettype wire

>>> design/clfsm_core.sv
// ----------------------------------------------------------------------------
// clfsm_core
// next-state and result logic for one request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clfsm_core #(
  parameter int ATTEMPT_BITS = 8
) (
  input  wire logic [1:0]              operation,
  input  wire logic [3:0]              outcome,
  input  wire clfsm_pkg::sup_state_t   state,
  input  wire logic [ATTEMPT_BITS-1:0] cnt,
  input  wire logic [7:0]              max_attempts,
  output clfsm_pkg::sup_state_t        state_nxt,
  output logic [ATTEMPT_BITS-1:0]      cnt_nxt,
  output logic [3:0]                   taken,
  output logic                         changed,
  output logic [7:0]                   attempts_used
);

  localparam int LW = (ATTEMPT_BITS > 8) ? ATTEMPT_BITS : 8;

  logic [LW-1:0]           lim_req;
  logic [LW-1:0]           cnt_max;
  logic [LW-1:0]           lim;
  logic [ATTEMPT_BITS-1:0] cnt_inc;
  logic                    hit;
  logic                    do_apply;
  logic                    clr_cnt;
  clfsm_pkg::mode_t        target;
  clfsm_pkg::mode_t        listed;
  logic [LW-1:0]           cnt_ext;

  // attempt limit, zero acts as one, clipped to the counter range
  assign lim_req = (max_attempts == 8'd0) ? LW'(1) : LW'(max_attempts);
  assign cnt_max = LW'({ATTEMPT_BITS{1'b1}});
  assign lim     = (lim_req > cnt_max) ? cnt_max : lim_req;
  assign cnt_inc = (cnt == {ATTEMPT_BITS{1'b1}}) ? cnt : cnt + ATTEMPT_BITS'(1);
  assign hit     = LW'(cnt_inc) >= lim;
  assign listed  = clfsm_pkg::next_mode(state.cur, outcome);

  // next state
  always_comb begin
    state_nxt = state;
    cnt_nxt   = cnt;
    taken     = clfsm_pkg::TAKEN_NONE;
    do_apply  = 1'b0;
    clr_cnt   = 1'b0;
    target    = clfsm_pkg::M_START;
    unique case (operation)
      clfsm_pkg::OP_START: begin
        if (!state.alive) begin
          state_nxt.prev  = clfsm_pkg::M_START;
          state_nxt.cur   = clfsm_pkg::M_INIT;
          state_nxt.alive = 1'b1;
          cnt_nxt         = '0;
        end
      end
      clfsm_pkg::OP_STOP: begin
        state_nxt.alive = 1'b0;
      end
      clfsm_pkg::OP_REPORT: begin
        if (state.alive) begin
          if (state.cur == clfsm_pkg::M_CONF) begin
            if (outcome == clfsm_pkg::OC_CONFIG_OK) begin
              do_apply = 1'b1;
              clr_cnt  = 1'b1;
              if (!state.cfgd) begin
                state_nxt.cfgd = 1'b1;
                taken          = clfsm_pkg::OC_CONFIG_OK;
                target         = clfsm_pkg::M_READY;
              end else begin
                taken  = clfsm_pkg::OC_RECONFIG_OK;
                target = state.prev;
              end
            end else begin
              cnt_nxt = cnt_inc;
              if (hit) begin
                do_apply = 1'b1;
                taken    = clfsm_pkg::OC_CONFIG_FAIL;
                target   = clfsm_pkg::M_STOP;
              end
            end
          end else if (state.cur == clfsm_pkg::M_RECOV) begin
            if (outcome == clfsm_pkg::OC_RECOV_OK) begin
              do_apply = 1'b1;
              clr_cnt  = 1'b1;
              taken    = clfsm_pkg::OC_RECOV_OK;
              target   = state.prev;
            end else begin
              cnt_nxt = cnt_inc;
              if (hit) begin
                do_apply = 1'b1;
                taken    = clfsm_pkg::OC_RECOV_FAIL;
                target   = clfsm_pkg::M_STOP;
              end
            end
          end else begin
            do_apply = 1'b1;
            taken    = (outcome < clfsm_pkg::TAKEN_NONE) ? outcome : clfsm_pkg::TAKEN_NONE;
            target   = (listed == clfsm_pkg::M_NONE) ? state.prev : listed;
          end
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase

    if (do_apply) begin
      if (target != state.cur) cnt_nxt = '0;
      state_nxt.prev = state.cur;
      state_nxt.cur  = target;
      if (target == clfsm_pkg::M_STOP) begin
        state_nxt.alive = 1'b0;
        cnt_nxt         = '0;
      end
    end
    if (clr_cnt) cnt_nxt = '0;
  end

  // result fields
  always_comb begin
    cnt_ext       = LW'(cnt_nxt);
    changed       = (state_nxt.cur != state.cur);
    attempts_used = cnt_ext[7:0];
  end

endmodule

`default_nettype wire

>>> design/component_lifecycle_fsm.sv
// ----------------------------------------------------------------------------
// component_lifecycle_fsm: each request passes the input register, then the result register
// throughput one request per cycle while out_stall is low
// rst_n low at a clock edge: start state, flags and count clear, limit 3
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module component_lifecycle_fsm #(
  parameter int ATTEMPT_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [3:0] in_outcome,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_state_now,
  output logic [2:0]      out_state_before,
  output logic [3:0]      out_taken,
  output logic            out_changed,
  output logic [7:0]      out_attempts_used,
  output logic            out_was_configured,
  output logic            out_active
);

  logic                    s1_valid;
  logic [1:0]              s1_operation;
  logic [3:0]              s1_outcome;
  logic                    out_free;
  logic                    take;

  logic [7:0]              max_attempts_r;
  clfsm_pkg::sup_state_t   state_r;
  clfsm_pkg::sup_state_t   state_nxt;
  logic [ATTEMPT_BITS-1:0] cnt_r;
  logic [ATTEMPT_BITS-1:0] cnt_nxt;
  logic [3:0]              taken;
  logic                    changed;
  logic [7:0]              attempts_used;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [2:0]              now_r;
  logic [2:0]              before_r;
  logic [3:0]              taken_r;
  logic                    changed_r;
  logic [7:0]              used_r;
  logic                    cfgd_r;
  logic                    active_r;

  assign out_free = !out_valid_r || !out_stall;
  assign take     = s1_valid && out_free;

  clfsm_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_outcome   (in_outcome),
    .take         (out_free),
    .s1_valid     (s1_valid),
    .s1_operation (s1_operation),
    .s1_outcome   (s1_outcome)
  );

  clfsm_core #(
    .ATTEMPT_BITS (ATTEMPT_BITS)
  ) u_core (
    .operation     (s1_operation),
    .outcome       (s1_outcome),
    .state         (state_r),
    .cnt           (cnt_r),
    .max_attempts  (max_attempts_r),
    .state_nxt     (state_nxt),
    .cnt_nxt       (cnt_nxt),
    .taken         (taken),
    .changed       (changed),
    .attempts_used (attempts_used)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_attempts_r <= clfsm_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_wr_en) begin
      max_attempts_r <= cfg_wr_data;
    end
  end

  // supervisor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{cur: clfsm_pkg::M_START, prev: clfsm_pkg::M_START,
                   cfgd: 1'b0, alive: 1'b0};
      cnt_r   <= '0;
    end else if (take) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid_nxt = out_free ? s1_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      now_r     <= state_nxt.cur;
      before_r  <= state_nxt.prev;
      taken_r   <= taken;
      changed_r <= changed;
      used_r    <= attempts_used;
      cfgd_r    <= state_nxt.cfgd;
      active_r  <= state_nxt.alive;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_state_now      = now_r;
  assign out_state_before   = before_r;
  assign out_taken          = taken_r;
  assign out_changed        = changed_r;
  assign out_attempts_used  = used_r;
  assign out_was_configured = cfgd_r;
  assign out_active         = active_r;

endmodule

`default_nettype wire

>>> design/clfsm_checker.sv
// ----------------------------------------------------------------------------
// clfsm_checker
// port-level checks on the lifecycle supervisor results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "component_lifecycle_fsm_assert.svh"

module clfsm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_state_now,
  input wire logic [3:0] out_taken,
  input wire logic       out_changed,
  input wire logic [7:0] out_attempts_used,
  input wire logic       out_active
);

  `CLFSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_state_now) && $stable(out_taken) && $stable(out_attempts_used),
    "stalled result changed")

  `CLFSM_ASSERT_ALWAYS(a_stop_inactive, clk, rst_n,
    !out_valid || out_state_now != clfsm_pkg::M_STOP || !out_active,
    "active while stopped")

  `CLFSM_ASSERT_ALWAYS(a_count_where, clk, rst_n,
    !out_valid || out_attempts_used == 8'd0 || out_state_now == clfsm_pkg::M_CONF ||
    out_state_now == clfsm_pkg::M_RECOV,
    "attempt count outside configuring or recovering")

  `CLFSM_ASSERT_ALWAYS(a_change_clears, clk, rst_n,
    !out_valid || !out_changed || out_attempts_used == 8'd0,
    "state change kept attempt count")

endmodule

bind component_lifecycle_fsm clfsm_checker u_clfsm_checker (.*);

`default_nettype wire
